// ----- hw/rtl/tdss_pkg.sv -----
// Shared types, command codes and glyph tables for the three-digit segment serializer.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package tdss_pkg;

  // Command codes carried in the request
  localparam logic [1:0] CMD_SHOW_NUMBER  = 2'd0;
  localparam logic [1:0] CMD_SHOW_LETTERS = 2'd1;
  localparam logic [1:0] CMD_BLANK        = 2'd2;
  localparam logic [1:0] CMD_RESTORE      = 2'd3;

  // Frame geometry: three glyphs of eight bits each
  localparam int unsigned GLYPH_W   = 8;
  localparam int unsigned FRAME_W   = 3 * GLYPH_W;
  localparam int unsigned BITCNT_W  = $clog2(FRAME_W + 1);

  // Letter window and table offsets
  localparam logic [7:0] CHAR_FIRST = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LAST  = 8'h73;  // 's'
  localparam logic [7:0] LEFT_BIAS  = 8'd86;
  localparam logic [7:0] RIGHT_BIAS = 8'd87;

  // Reciprocal of 1000 scaled by 2^26, rounded up; exact for all 16-bit values
  localparam logic [16:0] MOD_RECIP  = 17'd67109;
  localparam int unsigned MOD_SHIFT  = 26;

  // Glyph tables, padded to 32 entries with blank glyphs
  localparam logic [7:0] GLYPH_LEFT [32] = '{
    8'h77, 8'h41, 8'h3B, 8'h6B, 8'h4D, 8'h6E, 8'h7E, 8'h43, 8'h7F, 8'h6F,
    8'h80, 8'h5F, 8'h7C, 8'h38, 8'h79, 8'h3F, 8'h1E, 8'h7E, 8'h5C, 8'h40,
    8'h61, 8'h5C, 8'h34, 8'h57, 8'h58, 8'h78, 8'h1F, 8'h4F, 8'h18, 8'h6E,
    8'h00, 8'h00
  };

  localparam logic [7:0] GLYPH_MIDDLE [32] = '{
    8'h7B, 8'h41, 8'h37, 8'h67, 8'h4D, 8'h6E, 8'h7E, 8'h43, 8'h7F, 8'h6F,
    8'h80, 8'h5F, 8'h7C, 8'h34, 8'h75, 8'h3F, 8'h1E, 8'h7E, 8'h5C, 8'h40,
    8'h61, 8'h5C, 8'h38, 8'h5B, 8'h54, 8'h74, 8'h1F, 8'h4F, 8'h14, 8'h6E,
    8'h00, 8'h00
  };

  localparam logic [7:0] GLYPH_RIGHT [32] = '{
    8'hB7, 8'h81, 8'h73, 8'hE3, 8'hC5, 8'hE6, 8'hF6, 8'h83, 8'hF7, 8'hE7,
    8'hD7, 8'hF4, 8'h70, 8'hF1, 8'h77, 8'h56, 8'hF6, 8'hD4, 8'h80, 8'hA1,
    8'hD4, 8'h34, 8'h97, 8'hD0, 8'hF0, 8'h57, 8'hC7, 8'h50, 8'hE6, 8'h00,
    8'h00, 8'h00
  };

  // Input request
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] number;
    logic [7:0]  char_left;
    logic [7:0]  char_middle;
    logic [7:0]  char_right;
  } tdss_in_t;

  // One serial result item
  typedef struct packed {
    logic pulse_kind;
    logic data_bit;
    logic bad_char;
    logic last;
  } tdss_out_t;

  // After the modulo-1000 step
  typedef struct packed {
    logic [1:0] command;
    logic [9:0] value;
    logic [7:0] char_left;
    logic [7:0] char_middle;
    logic [7:0] char_right;
  } tdss_mod_t;

  // After the hundreds split
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] hundreds;
    logic [6:0] rest;
    logic [7:0] char_left;
    logic [7:0] char_middle;
    logic [7:0] char_right;
  } tdss_hund_t;

  // Frame ready for the serializer; right glyph in the top byte
  typedef struct packed {
    logic [FRAME_W-1:0] glyphs;
    logic               with_reset;
    logic               bad;
  } tdss_frame_t;

endpackage

`default_nettype wire

// ----- hw/rtl/three_digit_segment_serializer_top.sv -----
// Top level of the three-digit segment serializer: input register, digit split,
// glyph stage and serializer. Depends on tdss_pkg, tdss_digits, tdss_glyph, tdss_serializer.
`default_nettype none

// Each command produces a stream of result items for an external display shift
// register, one item per cycle while out_ready is high: show number, show letters
// and restore give a reset pulse and 24 data bits, blank gives 24 data bits. The
// serializer's one-bit-per-cycle shift register sets the rate, and consecutive
// frames follow with no gap. Up to four further commands are held in the input
// register and the three decode stages while a frame streams out; a command passes
// through the input register, the two digit stages, the glyph register and the
// serializer on its way out. Restore shows the number of the most recent earlier
// show-number request (zero after reset).
module three_digit_segment_serializer_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tdss_pkg::tdss_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tdss_pkg::tdss_out_t      out_data
);
  import tdss_pkg::*;

  tdss_in_t     in_r, in_nxt;
  logic         in_valid_r, in_valid_nxt;
  logic         req_ready;
  logic         hund_valid, hund_ready;
  tdss_hund_t   hund;
  logic         frame_valid, frame_ready;
  tdss_frame_t  frame;

  // Input register
  assign in_ready = !in_valid_r || req_ready;

  always_comb begin
    in_nxt       = in_r;
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_nxt       = in_data;
      in_valid_nxt = 1'b1;
    end else if (req_ready) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

  tdss_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid_r),
    .req_ready  (req_ready),
    .req        (in_r),
    .hund_valid (hund_valid),
    .hund_ready (hund_ready),
    .hund       (hund)
  );

  tdss_glyph u_glyph (
    .clk         (clk),
    .rst_n       (rst_n),
    .hund_valid  (hund_valid),
    .hund_ready  (hund_ready),
    .hund        (hund),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  tdss_serializer u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/tdss_digits.sv -----
// Decimal digit split: modulo 1000, then hundreds and remainder, one register stage each.
// Holds the remembered number. Depends on tdss_pkg.
`default_nettype none

module tdss_digits (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire tdss_pkg::tdss_in_t   req,
  output logic                      hund_valid,
  input  wire logic                 hund_ready,
  output tdss_pkg::tdss_hund_t      hund
);
  import tdss_pkg::*;

  logic [15:0]  shown_r, shown_nxt;
  logic [15:0]  num_sel;
  logic [32:0]  recip_prod;
  logic [6:0]   quot;
  logic [16:0]  quot_k;
  logic [15:0]  mod_diff;
  tdss_mod_t    a_r, a_nxt;
  logic         a_valid_r, a_valid_nxt;
  logic         a_ready, a_load;
  logic         b_ready_int;
  logic [15:0]  h_prod;
  logic [3:0]   hund_digit;
  logic [9:0]   hund_k;
  logic [9:0]   rest_diff;
  tdss_hund_t   b_r, b_nxt;
  logic         b_valid_r, b_valid_nxt;
  logic         b_load;

  // Stage A: choose the number and reduce it modulo 1000
  always_comb begin
    num_sel    = (req.command == CMD_RESTORE) ? shown_r : req.number;
    recip_prod = 33'(num_sel) * 33'(MOD_RECIP);
    quot       = recip_prod[32:MOD_SHIFT];
    quot_k     = {quot, 10'b0} - 17'({quot, 4'b0}) - 17'({quot, 3'b0});
    mod_diff   = num_sel - quot_k[15:0];
  end

  assign a_ready = !a_valid_r || b_ready_int;
  assign a_load  = req_valid && a_ready;
  assign req_ready = a_ready;

  assign b_ready_int = !b_valid_r || hund_ready;

  always_comb begin
    a_nxt             = a_r;
    a_valid_nxt       = a_valid_r;
    shown_nxt         = shown_r;
    if (a_load) begin
      a_nxt.command     = req.command;
      a_nxt.value       = mod_diff[9:0];
      a_nxt.char_left   = req.char_left;
      a_nxt.char_middle = req.char_middle;
      a_nxt.char_right  = req.char_right;
      a_valid_nxt       = 1'b1;
      if (req.command == CMD_SHOW_NUMBER) begin
        shown_nxt = req.number;
      end
    end else if (b_ready_int) begin
      a_valid_nxt = 1'b0;
    end
  end

  // Stage B: hundreds by reciprocal 41/4096, then the remainder below 100
  always_comb begin
    h_prod     = {6'b0, a_r.value} + {1'b0, a_r.value, 5'b0} + {3'b0, a_r.value, 3'b0};
    hund_digit = h_prod[15:12];
    hund_k     = {hund_digit, 6'b0} + {1'b0, hund_digit, 5'b0} + {4'b0, hund_digit, 2'b0};
    rest_diff  = a_r.value - hund_k;
  end

  assign b_load = a_valid_r && b_ready_int;

  always_comb begin
    b_nxt       = b_r;
    b_valid_nxt = b_valid_r;
    if (b_load) begin
      b_nxt.command     = a_r.command;
      b_nxt.hundreds    = hund_digit;
      b_nxt.rest        = rest_diff[6:0];
      b_nxt.char_left   = a_r.char_left;
      b_nxt.char_middle = a_r.char_middle;
      b_nxt.char_right  = a_r.char_right;
      b_valid_nxt       = 1'b1;
    end else if (hund_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      shown_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      shown_r   <= shown_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign hund_valid = b_valid_r;
  assign hund       = b_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tdss_glyph.sv -----
// Glyph stage: tens and units split, letter checks and table lookups into one frame.
// Depends on tdss_pkg.
`default_nettype none

module tdss_glyph (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  hund_valid,
  output logic                       hund_ready,
  input  wire tdss_pkg::tdss_hund_t  hund,
  output logic                       frame_valid,
  input  wire logic                  frame_ready,
  output tdss_pkg::tdss_frame_t      frame
);
  import tdss_pkg::*;

  logic [13:0]  t_prod;
  logic [3:0]   tens;
  logic [6:0]   tens_k;
  logic [6:0]   units_diff;
  logic         ok_left, ok_middle, ok_right;
  logic [4:0]   idx_left, idx_middle, idx_right;
  logic [7:0]   g_left, g_middle, g_right;
  tdss_frame_t  frame_r, frame_nxt;
  logic         valid_r, valid_nxt;
  logic         load;

  // Tens by reciprocal 103/1024, units from what is left
  always_comb begin
    t_prod     = {7'b0, hund.rest} + {1'b0, hund.rest, 6'b0} + {2'b0, hund.rest, 5'b0}
               + {5'b0, hund.rest, 2'b0} + {6'b0, hund.rest, 1'b0};
    tens       = t_prod[13:10];
    tens_k     = {tens, 3'b0} + {2'b0, tens, 1'b0};
    units_diff = hund.rest - tens_k;
  end

  // Letter range checks and table indexes
  always_comb begin
    ok_left    = (hund.char_left   >= CHAR_FIRST) && (hund.char_left   <= CHAR_LAST);
    ok_middle  = (hund.char_middle >= CHAR_FIRST) && (hund.char_middle <= CHAR_LAST);
    ok_right   = (hund.char_right  >= CHAR_FIRST) && (hund.char_right  <= CHAR_LAST);
    idx_left   = 5'(hund.char_left   - LEFT_BIAS);
    idx_middle = 5'(hund.char_middle - LEFT_BIAS);
    idx_right  = 5'(hund.char_right  - RIGHT_BIAS);
  end

  // Pick glyphs by command
  always_comb begin
    g_left   = '0;
    g_middle = '0;
    g_right  = '0;
    case (hund.command)
      CMD_SHOW_NUMBER, CMD_RESTORE: begin
        g_left   = GLYPH_LEFT[{1'b0, hund.hundreds}];
        g_middle = GLYPH_MIDDLE[{1'b0, tens}];
        g_right  = GLYPH_RIGHT[{1'b0, units_diff[3:0]}];
      end
      CMD_SHOW_LETTERS: begin
        g_left   = ok_left   ? GLYPH_LEFT[idx_left]     : 8'h00;
        g_middle = ok_middle ? GLYPH_MIDDLE[idx_middle] : 8'h00;
        g_right  = ok_right  ? GLYPH_RIGHT[idx_right]   : 8'h00;
      end
      default: begin
        g_left   = '0;
        g_middle = '0;
        g_right  = '0;
      end
    endcase
  end

  assign hund_ready = !valid_r || frame_ready;
  assign load       = hund_valid && hund_ready;

  always_comb begin
    frame_nxt = frame_r;
    valid_nxt = valid_r;
    if (load) begin
      frame_nxt.glyphs     = {g_right, g_middle, g_left};
      frame_nxt.with_reset = (hund.command != CMD_BLANK);
      frame_nxt.bad        = (hund.command == CMD_SHOW_LETTERS)
                             && !(ok_left && ok_middle && ok_right);
      valid_nxt            = 1'b1;
    end else if (frame_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign frame_valid = valid_r;
  assign frame       = frame_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tdss_serializer.sv -----
// Serializer: optional reset pulse, then 24 frame bits MSB first, one result per cycle unless out_ready stalls.
// Loads the next frame on the cycle its predecessor's last bit is taken. Depends on tdss_pkg.
`default_nettype none

module tdss_serializer (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   frame_valid,
  output logic                        frame_ready,
  input  wire tdss_pkg::tdss_frame_t  frame,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tdss_pkg::tdss_out_t         out_data
);
  import tdss_pkg::*;

  logic                busy_r, busy_nxt;
  logic                pulse_r, pulse_nxt;
  logic [BITCNT_W-1:0] left_r, left_nxt;
  logic [FRAME_W-1:0]  shift_r, shift_nxt;
  logic                bad_r, bad_nxt;
  logic                last_w;
  logic                take;

  assign last_w      = !pulse_r && (left_r == BITCNT_W'(1));
  assign take        = busy_r && out_ready;
  assign frame_ready = !busy_r || (out_ready && last_w);

  // Advance through the frame, or load the next one
  always_comb begin
    busy_nxt  = busy_r;
    pulse_nxt = pulse_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    bad_nxt   = bad_r;
    if (frame_valid && frame_ready) begin
      busy_nxt  = 1'b1;
      pulse_nxt = frame.with_reset;
      left_nxt  = BITCNT_W'(FRAME_W);
      shift_nxt = frame.glyphs;
      bad_nxt   = frame.bad;
    end else if (take) begin
      if (pulse_r) begin
        pulse_nxt = 1'b0;
      end else begin
        shift_nxt = {shift_r[FRAME_W-2:0], 1'b0};
        left_nxt  = left_r - BITCNT_W'(1);
        if (last_w) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pulse_r <= 1'b0;
      left_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      pulse_r <= pulse_nxt;
      left_r  <= left_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bad_r   <= bad_nxt;
  end

  // Result straight from registers
  assign out_valid           = busy_r;
  assign out_data.pulse_kind = !pulse_r;
  assign out_data.data_bit   = pulse_r ? 1'b0 : shift_r[FRAME_W-1];
  assign out_data.bad_char   = bad_r;
  assign out_data.last       = last_w;

endmodule

`default_nettype wire

// ----- hw/rtl/tdss_checker.sv -----
// Port-level checks for the three-digit segment serializer, bound to the top level.
// Depends on tdss_pkg and three_digit_segment_serializer_top.
`default_nettype none

module tdss_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire tdss_pkg::tdss_out_t  out_data
);
  import tdss_pkg::*;

  logic out_take;
  assign out_take = out_valid && out_ready;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A reset pulse carries a low data level and never ends a frame
  a_pulse_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pulse_kind |-> !out_data.data_bit && !out_data.last)
    else $error("malformed reset pulse");

  // A frame streams without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_data.last |=> out_valid)
    else $error("gap inside a frame");

  // The bad-letter flag stays constant through a frame
  a_bad_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_data.last |=> out_data.bad_char == $past(out_data.bad_char))
    else $error("bad_char changed inside a frame");

endmodule

bind three_digit_segment_serializer_top tdss_checker u_tdss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- verif/three_digit_segment_serializer_top_test.sv -----
// Self-checking testbench for three_digit_segment_serializer_top: queued requests, a
// clocked driver and monitor, and a built-in predictor of the serial segment stream.
// Depends on tdss_pkg for the request and result types and the command codes.
module three_digit_segment_serializer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdss_pkg::*;

  // Letter window and table offsets as the display defines them
  localparam logic [7:0] LETTER_A     = 8'h61;
  localparam logic [7:0] LETTER_S     = 8'h73;
  localparam int         LEFT_OFFSET  = 86;
  localparam int         RIGHT_OFFSET = 87;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 60;
  localparam int         MAX_REPORTS  = 20;

  // Position glyph tables, independent of the design's copy
  localparam logic [7:0] LEFT_SEG [30] = '{
    8'h77, 8'h41, 8'h3B, 8'h6B, 8'h4D, 8'h6E, 8'h7E, 8'h43, 8'h7F, 8'h6F,
    8'h80, 8'h5F, 8'h7C, 8'h38, 8'h79, 8'h3F, 8'h1E, 8'h7E, 8'h5C, 8'h40,
    8'h61, 8'h5C, 8'h34, 8'h57, 8'h58, 8'h78, 8'h1F, 8'h4F, 8'h18, 8'h6E
  };
  localparam logic [7:0] MIDDLE_SEG [30] = '{
    8'h7B, 8'h41, 8'h37, 8'h67, 8'h4D, 8'h6E, 8'h7E, 8'h43, 8'h7F, 8'h6F,
    8'h80, 8'h5F, 8'h7C, 8'h34, 8'h75, 8'h3F, 8'h1E, 8'h7E, 8'h5C, 8'h40,
    8'h61, 8'h5C, 8'h38, 8'h5B, 8'h54, 8'h74, 8'h1F, 8'h4F, 8'h14, 8'h6E
  };
  localparam logic [7:0] RIGHT_SEG [29] = '{
    8'hB7, 8'h81, 8'h73, 8'hE3, 8'hC5, 8'hE6, 8'hF6, 8'h83, 8'hF7, 8'hE7,
    8'hD7, 8'hF4, 8'h70, 8'hF1, 8'h77, 8'h56, 8'hF6, 8'hD4, 8'h80, 8'hA1,
    8'hD4, 8'h34, 8'h97, 8'hD0, 8'hF0, 8'h57, 8'hC7, 8'h50, 8'hE6
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tdss_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tdss_out_t out_data;

  tdss_in_t  requests_to_send [$];
  tdss_out_t segment_items_due [$];
  logic [15:0] remembered_number = '0;
  int send_idle_pct = 19;
  int recv_idle_pct = 64;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  int errors = 0;
  int items_checked = 0;
  int requests_taken = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int bad_frames = 0;

  three_digit_segment_serializer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one frame: optional register-reset pulse, then 24 bits MSB first
  task automatic push_frame(input logic [23:0] glyphs, input logic with_pulse,
                            input logic bad);
    tdss_out_t item;
    if (with_pulse) begin
      item = '{pulse_kind: 1'b0, data_bit: 1'b0, bad_char: bad, last: 1'b0};
      segment_items_due.push_back(item);
    end
    for (int b = 23; b >= 0; b--) begin
      item = '{pulse_kind: 1'b1, data_bit: glyphs[b], bad_char: bad, last: (b == 0)};
      segment_items_due.push_back(item);
    end
  endtask

  function automatic logic [23:0] number_glyphs(input logic [15:0] n);
    int v;
    v = int'(n) % 1000;
    return {RIGHT_SEG[v % 10], MIDDLE_SEG[(v / 10) % 10], LEFT_SEG[v / 100]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c >= LETTER_A && c <= LETTER_S;
  endfunction

  // Work out the segment stream that one accepted request causes
  task automatic predict_segment_items(input tdss_in_t req);
    logic [7:0] gl, gm, gr;
    logic bad;
    cmd_count[req.command]++;
    case (req.command)
      CMD_SHOW_NUMBER: begin
        remembered_number = req.number;
        push_frame(number_glyphs(req.number), 1'b1, 1'b0);
      end
      CMD_RESTORE: begin
        push_frame(number_glyphs(remembered_number), 1'b1, 1'b0);
      end
      CMD_BLANK: begin
        push_frame('0, 1'b0, 1'b0);
      end
      default: begin
        bad = 1'b0;
        gl = '0;
        gm = '0;
        gr = '0;
        if (is_letter(req.char_left)) gl = LEFT_SEG[int'(req.char_left) - LEFT_OFFSET];
        else bad = 1'b1;
        if (is_letter(req.char_middle)) gm = MIDDLE_SEG[int'(req.char_middle) - LEFT_OFFSET];
        else bad = 1'b1;
        if (is_letter(req.char_right)) gr = RIGHT_SEG[int'(req.char_right) - RIGHT_OFFSET];
        else bad = 1'b1;
        if (bad) bad_frames++;
        push_frame({gr, gm, gl}, 1'b1, bad);
      end
    endcase
  endtask

  // Drive requests; predict on each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_segment_items(in_data);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (requests_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= requests_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random, or fully during a hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Hold the receiver off for a long stretch so the input backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check each accepted result item against the oldest expectation
  always @(posedge clk) begin
    tdss_out_t want;
    if (rst_n && out_valid && out_ready) begin
      items_checked++;
      if (segment_items_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with none expected: actual %p", $time, out_data);
      end else begin
        want = segment_items_due.pop_front();
        if (out_data.pulse_kind !== want.pulse_kind || out_data.data_bit !== want.data_bit ||
            out_data.bad_char !== want.bad_char || out_data.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
        end
      end
    end
  end

  task automatic add_request(input logic [1:0] cmd, input logic [15:0] num,
                             input logic [7:0] cl, input logic [7:0] cm,
                             input logic [7:0] cr);
    tdss_in_t req;
    req.command     = cmd;
    req.number      = num;
    req.char_left   = cl;
    req.char_middle = cm;
    req.char_right  = cr;
    requests_to_send.push_back(req);
  endtask

  function automatic logic [7:0] random_code();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(int'(LETTER_A), int'(LETTER_S)));
  endfunction

  task automatic add_random(input int count);
    int pick;
    logic [1:0] cmd;
    logic [15:0] num;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_SHOW_NUMBER;
      else if (pick < 65) cmd = CMD_SHOW_LETTERS;
      else if (pick < 80) cmd = CMD_BLANK;
      else cmd = CMD_RESTORE;
      if ($urandom_range(0, 3) == 0) num = 16'($urandom_range(0, 999));
      else num = 16'($urandom_range(0, 65535));
      add_request(cmd, num, random_code(), random_code(), random_code());
    end
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || in_valid || segment_items_due.size() != 0);
  endtask

  // Stimulus sequence and end of run
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Restore straight after reset shows zero
    add_request(CMD_RESTORE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    add_request(CMD_SHOW_NUMBER, 16'd0, 8'h00, 8'h00, 8'h00);
    add_request(CMD_SHOW_NUMBER, 16'd999, 8'hFF, 8'hFF, 8'hFF);
    add_request(CMD_SHOW_NUMBER, 16'd1000, 8'h61, 8'h62, 8'h63);
    add_request(CMD_SHOW_NUMBER, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    add_request(CMD_SHOW_NUMBER, 16'd123, 8'h00, 8'h00, 8'h00);
    add_request(CMD_SHOW_NUMBER, 16'd456, 8'h00, 8'h00, 8'h00);
    add_request(CMD_SHOW_NUMBER, 16'd789, 8'h00, 8'h00, 8'h00);
    add_request(CMD_RESTORE, 16'd0, 8'h00, 8'h00, 8'h00);
    add_request(CMD_BLANK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    // Letters: window edges, one bad position at a time, all bad
    add_request(CMD_SHOW_LETTERS, 16'hFFFF, 8'h61, 8'h61, 8'h61);
    add_request(CMD_SHOW_LETTERS, 16'h0000, 8'h73, 8'h73, 8'h73);
    add_request(CMD_SHOW_LETTERS, 16'h0000, 8'h60, 8'h6D, 8'h73);
    add_request(CMD_SHOW_LETTERS, 16'h0000, 8'h61, 8'h74, 8'h63);
    add_request(CMD_SHOW_LETTERS, 16'h0000, 8'h61, 8'h62, 8'hFF);
    add_request(CMD_SHOW_LETTERS, 16'h0000, 8'h00, 8'h00, 8'h00);
    add_request(CMD_SHOW_LETTERS, 16'h0000, 8'hFF, 8'hFF, 8'h60);
    // Letters and blank leave the remembered number alone
    add_request(CMD_RESTORE, 16'd5, 8'h00, 8'h00, 8'h00);
    add_request(CMD_BLANK, 16'h0000, 8'h00, 8'h00, 8'h00);
    add_request(CMD_SHOW_NUMBER, 16'd65000, 8'hFF, 8'hFF, 8'hFF);
    add_request(CMD_RESTORE, 16'h0000, 8'h00, 8'h00, 8'h00);

    add_random(27);
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 19;
    add_random(27);
    wait_drained();

    // No idling, with a long receiver hold-off while requests keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(25);
    hold_go = 1'b1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d show number, %0d letters (%0d with bad codes),",
             requests_taken, cmd_count[CMD_SHOW_NUMBER], cmd_count[CMD_SHOW_LETTERS],
             bad_frames);
    $display("%0d blank, %0d restore; %0d segment items checked, %0d errors.",
             cmd_count[CMD_BLANK], cmd_count[CMD_RESTORE], items_checked, errors);
    if (errors == 0 && segment_items_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("%0t: timeout with %0d requests queued and %0d items outstanding",
             $time, requests_to_send.size(), segment_items_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tdss_pkg.sv
hw/rtl/tdss_digits.sv
hw/rtl/tdss_glyph.sv
hw/rtl/tdss_serializer.sv
hw/rtl/three_digit_segment_serializer_top.sv
hw/rtl/tdss_checker.sv
verif/three_digit_segment_serializer_top_test.sv
